[hw/rtl/vsd_pkg.sv]
package vsd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PayloadW = 7;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned ShiftW   = 6;

  localparam logic [LenW-1:0]   Limit32 = 4'd5;
  localparam logic [LenW-1:0]   Limit64 = 4'd9;
  localparam logic [ValueW-1:0] Top32   = 64'h0000_0000_8000_0000;
  localparam logic [ValueW-1:0] Top64   = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] Mask32  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [ValueW-1:0] Mask64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ShiftW-1:0] DigitW  = 6'd7;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   byte_length;
  } vsd_result_t;

  // status of one decode step
  typedef struct packed {
    logic        done;
    vsd_result_t res;
  } vsd_step_t;

endpackage

[hw/rtl/vsd_byte_if.sv]
interface vsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[hw/rtl/vsd_result_if.sv]
interface vsd_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [3:0]  byte_length;

  modport source (output valid, output value, output byte_length, input ready);
  modport sink (input valid, input value, input byte_length, output ready);
endinterface

[hw/rtl/vsd_in_stage.sv]
module vsd_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  vsd_byte_if.sink                 byte_i,
  input  logic                     advance_i,
  output logic                     valid_o,
  output logic [vsd_pkg::ByteW-1:0] byte_o
);
  import vsd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             take;

  assign byte_i.ready = !valid_q || advance_i;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_i.in_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

[hw/rtl/vsd_core.sv]
module vsd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wide_i,
  input  logic                      step_i,
  input  logic [vsd_pkg::ByteW-1:0] byte_i,
  output vsd_pkg::vsd_step_t        step_o
);
  import vsd_pkg::*;

  logic [ValueW-1:0] acc_q, acc_d;
  logic [LenW-1:0]   cnt_q, cnt_d;

  logic [ShiftW-1:0] shift;
  logic [ValueW-1:0] placed;
  logic [ValueW-1:0] mask;
  logic [ValueW-1:0] sum;
  logic [LenW-1:0]   count;
  logic [LenW-1:0]   limit;
  logic              cont;
  logic              last;

  always_comb begin
    cont   = byte_i[ByteW-1];
    shift  = ShiftW'(cnt_q) * DigitW;
    placed = ValueW'(byte_i[PayloadW-1:0]) << shift;
    mask   = wide_i ? Mask64 : Mask32;
    limit  = wide_i ? Limit64 : Limit32;
    count  = cnt_q + 4'd1;
    last   = !cont || (count >= limit);
    // payload always lands above the bits already held
    sum    = (acc_q | placed) & mask;
    // adding the top bit with wrap flips it
    if (last && cont) begin
      sum = sum ^ (wide_i ? Top64 : Top32);
    end

    step_o.done            = last;
    step_o.res.value       = sum;
    step_o.res.byte_length = count;

    acc_d = acc_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (last) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = sum;
        cnt_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

[hw/rtl/vsd_out_stage.sv]
module vsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  vsd_pkg::vsd_result_t res_i,
  output logic                 space_o,
  vsd_result_if.source         result_o
);
  import vsd_pkg::*;

  logic        valid_q, valid_d;
  vsd_result_t res_q;

  assign space_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.value       = res_q.value;
  assign result_o.byte_length = res_q.byte_length;
endmodule

[hw/rtl/varint_stream_decoder_top.sv]
// unsigned leb128 varint decoder: takes one encoded byte per transaction on byte_i
// (bit 7 continuation, bits 6..0 payload, least significant group first) and
// emits one transaction on result_o per finished value, carrying the value and
// the number of bytes it used. a value ends on a byte with bit 7 clear or at the
// byte limit (5 bytes in 32-bit mode, 9 in 64-bit mode); if the limit byte still
// has bit 7 set, the top bit of the mode's width is toggled in. results are
// wrapped to 32 bits (upper bits zero) or 64 bits per wide_mode_i, which resets
// to 32-bit mode and should be written only while the block is idle. the result
// of a byte passes through the input register, then the result register, before
// it shows on result_o, and a new byte is taken every cycle as long as result_o
// is drained; the rate is set by the shift-and-or update of the accumulator
module varint_stream_decoder_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wide_mode_we_i,
  input  logic wide_mode_i,
  vsd_byte_if.sink     byte_i,
  vsd_result_if.source result_o
);
  import vsd_pkg::*;

  // mode register
  logic wide_q, wide_d;

  // input stage outputs
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  // decode step and handshake between stages
  vsd_step_t step;
  logic      out_space;
  logic      advance;
  logic      load;

  always_comb begin
    wide_d = wide_q;
    if (wide_mode_we_i) begin
      wide_d = wide_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
    end else begin
      wide_q <= wide_d;
    end
  end

  // a byte that ends a value needs room in the result register,
  // any other byte only updates the accumulator
  assign advance = in_valid && (!step.done || out_space);
  assign load    = advance && step.done;

  vsd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  vsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wide_i (wide_q),
    .step_i (advance),
    .byte_i (in_byte),
    .step_o (step)
  );

  vsd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .res_i    (step.res),
    .space_o  (out_space),
    .result_o (result_o)
  );
endmodule
